### sv/ggx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_pkg
// Shared constants, register codes and stage types of the GGX distribution
// and Smith lambda pipeline.
// ----------------------------------------------------------------------------
package ggx_pkg;

    // field widths
    localparam int unsigned DIR_W   = 16;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned SQ_W    = 31;

    // pi in unsigned Q2.30
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    // reset roughness, 1.0 in Q2.14
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd16384;

    // lambda is the square root minus one half in Q16.16
    localparam logic [32:0] LAM_OFFSET = 33'd32768;

    // stage counts of the pipeline sections
    localparam int unsigned FRONT_LAT = 3;
    localparam int unsigned DMUL_LAT  = 5;
    localparam int unsigned DDIV_LAT  = 33;
    localparam int unsigned LDIV_LAT  = 33;
    localparam int unsigned LSQRT_LAT = 17;
    localparam int unsigned LAM_LAT   = LDIV_LAT + LSQRT_LAT;
    localparam int unsigned DEN_DLY   = LAM_LAT - DMUL_LAT - DDIV_LAT;
    localparam int unsigned TOTAL_LAT = FRONT_LAT + LAM_LAT + 1;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_ALPHA_X = 1'b0,
        REG_ALPHA_Y = 1'b1
    } cfg_reg_t;

    // terms handed from the front section to both branches
    typedef struct packed {
        logic              grazing;
        logic [SQ_W-1:0]   z2;
        logic [63:0]       w;
        logic [63:0]       l;
        logic [62:0]       p0;
        logic [62:0]       p1;
        logic [63:0]       q0;
        logic [63:0]       q1;
    } front_t;

endpackage

### sv/ggx_ndf_and_smith_lambda.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_ndf_and_smith_lambda
// Depth: the path from input transfer to result is set by the lambda branch
// (3 front stages, 33 divider stages, 17 square root stages, output register).
// Throughput: one transfer per cycle; the whole pipeline advances together
// and holds while a result waits at the output.
// Reset: clears the valid bits and sets both roughness registers to 1.0.
// ----------------------------------------------------------------------------
module ggx_ndf_and_smith_lambda (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,   // density [31:0], smith_lambda [63:32]
    output logic [1:0]    m_axis_tuser,   // saturated [0], grazing [1]
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_addr,
    input  logic [15:0]   cfg_wdata
);
    import ggx_pkg::*;

    logic                en;
    logic [ALPHA_W-1:0]  alpha_x_reg, alpha_y_reg;
    logic                vld_reg [TOTAL_LAT];
    logic                graz_reg [LAM_LAT];
    logic [OUT_W:0]      dly_reg [DEN_DLY];

    front_t              front;
    logic [223:0]        den;
    logic [95:0]         cube;
    logic [OUT_W-1:0]    dens;
    logic                dens_sat;
    logic [65:0]         quo;
    logic [32:0]         root;
    logic [32:0]         lam;
    logic [63:0]         tdata_reg, tdata_next;
    logic [1:0]          tuser_reg, tuser_next;

    // one enable for every stage: move whenever the output slot frees up
    assign en            = !vld_reg[TOTAL_LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_x_reg <= ALPHA_RESET;
            alpha_y_reg <= ALPHA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ALPHA_X: alpha_x_reg <= cfg_wdata;
                REG_ALPHA_Y: alpha_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TOTAL_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < TOTAL_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    ggx_front u_front (
        .aclk    (aclk),
        .en      (en),
        .dir_x   (s_axis_tdata[15:0]),
        .dir_y   (s_axis_tdata[31:16]),
        .dir_z   (s_axis_tdata[47:32]),
        .alpha_x (alpha_x_reg),
        .alpha_y (alpha_y_reg),
        .front   (front)
    );

    // density branch
    ggx_dmul u_dmul (
        .aclk (aclk),
        .en   (en),
        .front(front),
        .den  (den),
        .cube (cube)
    );

    ggx_ddiv u_ddiv (
        .aclk    (aclk),
        .en      (en),
        .den     (den),
        .cube    (cube),
        .density (dens),
        .sat     (dens_sat)
    );

    // lambda branch
    ggx_ldiv u_ldiv (
        .aclk (aclk),
        .en   (en),
        .front(front),
        .quo  (quo)
    );

    ggx_lsqrt u_lsqrt (
        .aclk (aclk),
        .en   (en),
        .quo  (quo),
        .root (root)
    );

    // line up the grazing flag and the shorter density branch with lambda
    always_ff @(posedge aclk) begin
        if (en) begin
            graz_reg[0] <= front.grazing;
            for (int k = 1; k < LAM_LAT; k++) begin
                graz_reg[k] <= graz_reg[k-1];
            end
            dly_reg[0] <= {dens_sat, dens};
            for (int k = 1; k < DEN_DLY; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // lambda offset, clamp, and the grazing override
    always_comb begin
        lam = root - LAM_OFFSET;
        if (graz_reg[LAM_LAT-1]) begin
            tdata_next = '0;
            tuser_next = 2'b10;
        end else begin
            tdata_next[OUT_W-1:0]       = dly_reg[DEN_DLY-1][OUT_W-1:0];
            tdata_next[2*OUT_W-1:OUT_W] = lam[OUT_W] ? '1 : lam[OUT_W-1:0];
            tuser_next = {1'b0, dly_reg[DEN_DLY-1][OUT_W] | lam[OUT_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

endmodule

### sv/ggx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_front
// Squares of the direction components and roughness, then the weighted sums
// and partial products that feed the density and lambda branches.
// ----------------------------------------------------------------------------
module ggx_front (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [ggx_pkg::DIR_W-1:0]     dir_x,
    input  logic [ggx_pkg::DIR_W-1:0]     dir_y,
    input  logic [ggx_pkg::DIR_W-1:0]     dir_z,
    input  logic [ggx_pkg::ALPHA_W-1:0]   alpha_x,
    input  logic [ggx_pkg::ALPHA_W-1:0]   alpha_y,
    output ggx_pkg::front_t               front
);
    import ggx_pkg::*;

    logic [15:0] x_mag, y_mag, z_mag, ai, bi;
    logic [31:0] x_sq, y_sq, z_sq;

    logic [SQ_W-1:0] x2_reg, y2_reg, z2_reg;
    logic [31:0]     a2_reg, b2_reg, u_reg;
    logic            graz1_reg;

    logic [62:0]     xb_reg, ya_reg, xa_reg, yb_reg;
    logic [63:0]     u2_reg;
    logic [31:0]     u_s2_reg;
    logic [SQ_W-1:0] z2_s2_reg;
    logic            graz2_reg;

    front_t front_reg, front_next;

    // magnitudes, a zero roughness counts as one
    always_comb begin
        x_mag = dir_x[15] ? (~dir_x + 16'd1) : dir_x;
        y_mag = dir_y[15] ? (~dir_y + 16'd1) : dir_y;
        z_mag = dir_z[15] ? (~dir_z + 16'd1) : dir_z;
        ai    = (alpha_x == '0) ? 16'd1 : alpha_x;
        bi    = (alpha_y == '0) ? 16'd1 : alpha_y;
        x_sq  = 32'(x_mag) * 32'(x_mag);
        y_sq  = 32'(y_mag) * 32'(y_mag);
        z_sq  = 32'(z_mag) * 32'(z_mag);
    end

    // stage 1: squares
    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg    <= x_sq[SQ_W-1:0];
            y2_reg    <= y_sq[SQ_W-1:0];
            z2_reg    <= z_sq[SQ_W-1:0];
            a2_reg    <= 32'(ai) * 32'(ai);
            b2_reg    <= 32'(bi) * 32'(bi);
            u_reg     <= 32'(ai) * 32'(bi);
            graz1_reg <= (dir_z == '0);
        end
    end

    // stage 2: cross products with the roughness squares
    always_ff @(posedge aclk) begin
        if (en) begin
            xb_reg    <= 63'(x2_reg) * 63'(b2_reg);
            ya_reg    <= 63'(y2_reg) * 63'(a2_reg);
            xa_reg    <= 63'(x2_reg) * 63'(a2_reg);
            yb_reg    <= 63'(y2_reg) * 63'(b2_reg);
            u2_reg    <= 64'(u_reg) * 64'(u_reg);
            u_s2_reg  <= u_reg;
            z2_s2_reg <= z2_reg;
            graz2_reg <= graz1_reg;
        end
    end

    // stage 3: sums and halves of z^2 u^2 and u^3
    always_comb begin
        front_next.grazing = graz2_reg;
        front_next.z2      = z2_s2_reg;
        front_next.w       = (64'(z2_s2_reg) << 28) + 64'(xa_reg) + 64'(yb_reg);
        front_next.l       = 64'(xb_reg) + 64'(ya_reg);
        front_next.p0      = 63'(z2_s2_reg) * 63'(u2_reg[31:0]);
        front_next.p1      = 63'(z2_s2_reg) * 63'(u2_reg[63:32]);
        front_next.q0      = 64'(u_s2_reg) * 64'(u2_reg[31:0]);
        front_next.q1      = 64'(u_s2_reg) * 64'(u2_reg[63:32]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

### sv/ggx_dmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_dmul
// Builds the density divisor pi * N^2 and the numerator factor u^3 with
// 32 bit limb products, one register after each product row.
// ----------------------------------------------------------------------------
module ggx_dmul (
    input  logic             aclk,
    input  logic             en,
    input  ggx_pkg::front_t  front,
    output logic [223:0]     den,
    output logic [95:0]      cube
);
    import ggx_pkg::*;

    logic [95:0]  n_reg, p4_reg;
    logic [63:0]  sq00_reg, sq11_reg, sq22_reg, x01_reg, x02_reg, x12_reg;
    logic [95:0]  p5_reg, p6_reg, p7_reg, p8_reg;
    logic [191:0] s_reg;
    logic [63:0]  t_reg [6];
    logic [223:0] den_reg, den_next;

    // stage 4: N and u^3
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg  <= 96'(front.p0) + (96'(front.p1) << 32) + (96'(front.l) << 28);
            p4_reg <= 96'(front.q0) + (96'(front.q1) << 32);
        end
    end

    // stage 5: limb products of N^2
    always_ff @(posedge aclk) begin
        if (en) begin
            sq00_reg <= 64'(n_reg[31:0])  * 64'(n_reg[31:0]);
            sq11_reg <= 64'(n_reg[63:32]) * 64'(n_reg[63:32]);
            sq22_reg <= 64'(n_reg[95:64]) * 64'(n_reg[95:64]);
            x01_reg  <= 64'(n_reg[31:0])  * 64'(n_reg[63:32]);
            x02_reg  <= 64'(n_reg[31:0])  * 64'(n_reg[95:64]);
            x12_reg  <= 64'(n_reg[63:32]) * 64'(n_reg[95:64]);
            p5_reg   <= p4_reg;
        end
    end

    // stage 6: N^2, cross terms counted twice
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg  <= 192'(sq00_reg) + (192'(sq11_reg) << 64) + (192'(sq22_reg) << 128)
                    + (192'(x01_reg) << 33) + (192'(x02_reg) << 65)
                    + (192'(x12_reg) << 97);
            p6_reg <= p5_reg;
        end
    end

    // stage 7: pi times each limb of N^2
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                t_reg[k] <= 64'(PI_Q30) * 64'(s_reg[32*k +: 32]);
            end
            p7_reg <= p6_reg;
        end
    end

    // stage 8: gather the pi products
    always_comb begin
        den_next = '0;
        for (int k = 0; k < 6; k++) begin
            den_next = den_next + (224'(t_reg[k]) << (32 * k));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_next;
            p8_reg  <= p7_reg;
        end
    end

    assign den  = den_reg;
    assign cube = p8_reg;

endmodule

### sv/ggx_ddiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_ddiv
// Restoring divider for the density: overflow check, then one quotient bit
// per stage of 2^134 u^3 over pi N^2.
// ----------------------------------------------------------------------------
module ggx_ddiv (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [223:0]                den,
    input  logic [95:0]                 cube,
    output logic [ggx_pkg::OUT_W-1:0]   density,
    output logic                        sat
);
    import ggx_pkg::*;

    logic [255:0] rem_reg  [DDIV_LAT];
    logic [255:0] rem_next [DDIV_LAT];
    logic [223:0] den_reg  [DDIV_LAT];
    logic [223:0] den_next [DDIV_LAT];
    logic [31:0]  quo_reg  [DDIV_LAT];
    logic [31:0]  quo_next [DDIV_LAT];
    logic         sat_reg  [DDIV_LAT];
    logic         sat_next [DDIV_LAT];

    // first stage checks for overflow, later stages settle one bit each
    always_comb begin
        logic [255:0] num;
        logic [255:0] trial;
        num   = 256'(cube) << 134;
        trial = '0;
        for (int k = 0; k < DDIV_LAT; k++) begin
            if (k == 0) begin
                rem_next[k] = num;
                den_next[k] = den;
                quo_next[k] = '0;
                sat_next[k] = (num >= (256'(den) << 32));
            end else begin
                rem_next[k] = rem_reg[k-1];
                den_next[k] = den_reg[k-1];
                quo_next[k] = quo_reg[k-1];
                sat_next[k] = sat_reg[k-1];
                trial = 256'(den_reg[k-1]) << (DDIV_LAT - 1 - k);
                if (rem_reg[k-1] >= trial) begin
                    rem_next[k] = rem_reg[k-1] - trial;
                    quo_next[k][DDIV_LAT-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DDIV_LAT; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
                sat_reg[k] <= sat_next[k];
            end
        end
    end

    assign density = sat_reg[DDIV_LAT-1] ? '1 : quo_reg[DDIV_LAT-1];
    assign sat     = sat_reg[DDIV_LAT-1];

endmodule

### sv/ggx_ldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_ldiv
// Restoring divider for floor(4 W / z^2), two quotient bits per stage.
// ----------------------------------------------------------------------------
module ggx_ldiv (
    input  logic             aclk,
    input  logic             en,
    input  ggx_pkg::front_t  front,
    output logic [65:0]      quo
);
    import ggx_pkg::*;

    logic [65:0]     nq_reg  [LDIV_LAT];
    logic [65:0]     nq_next [LDIV_LAT];
    logic [SQ_W-1:0] rem_reg  [LDIV_LAT];
    logic [SQ_W-1:0] rem_next [LDIV_LAT];
    logic [SQ_W-1:0] z2_reg  [LDIV_LAT];
    logic [SQ_W-1:0] z2_next [LDIV_LAT];

    // numerator bits shift out at the top while quotient bits shift in below
    always_comb begin
        logic [65:0]     v;
        logic [SQ_W-1:0] r;
        logic [SQ_W-1:0] d;
        logic [SQ_W:0]   r2;
        v  = '0;
        r  = '0;
        d  = '0;
        r2 = '0;
        for (int k = 0; k < LDIV_LAT; k++) begin
            if (k == 0) begin
                v = {front.w, 2'b00};
                r = '0;
                d = front.z2;
            end else begin
                v = nq_reg[k-1];
                r = rem_reg[k-1];
                d = z2_reg[k-1];
            end
            for (int j = 0; j < 2; j++) begin
                r2 = {r, v[65]};
                v  = {v[64:0], 1'b0};
                if (r2 >= {1'b0, d}) begin
                    r2   = r2 - {1'b0, d};
                    v[0] = 1'b1;
                end
                r = r2[SQ_W-1:0];
            end
            nq_next[k]  = v;
            rem_next[k] = r;
            z2_next[k]  = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < LDIV_LAT; k++) begin
                nq_reg[k]  <= nq_next[k];
                rem_reg[k] <= rem_next[k];
                z2_reg[k]  <= z2_next[k];
            end
        end
    end

    assign quo = nq_reg[LDIV_LAT-1];

endmodule

### sv/ggx_lsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggx_lsqrt
// Digit by digit integer square root of the lambda quotient, two result
// bits per stage.
// ----------------------------------------------------------------------------
module ggx_lsqrt (
    input  logic          aclk,
    input  logic          en,
    input  logic [65:0]   quo,
    output logic [32:0]   root
);
    import ggx_pkg::*;

    logic [67:0] v_reg    [LSQRT_LAT];
    logic [67:0] v_next   [LSQRT_LAT];
    logic [34:0] rem_reg  [LSQRT_LAT];
    logic [34:0] rem_next [LSQRT_LAT];
    logic [33:0] rt_reg   [LSQRT_LAT];
    logic [33:0] rt_next  [LSQRT_LAT];

    // each step brings down two bits and tries root*4 + 1
    always_comb begin
        logic [67:0] v;
        logic [34:0] r;
        logic [33:0] s;
        logic [36:0] r4;
        logic [36:0] trial;
        v     = '0;
        r     = '0;
        s     = '0;
        r4    = '0;
        trial = '0;
        for (int k = 0; k < LSQRT_LAT; k++) begin
            if (k == 0) begin
                v = {2'b00, quo};
                r = '0;
                s = '0;
            end else begin
                v = v_reg[k-1];
                r = rem_reg[k-1];
                s = rt_reg[k-1];
            end
            for (int j = 0; j < 2; j++) begin
                r4    = {r, v[67:66]};
                v     = {v[65:0], 2'b00};
                trial = {1'b0, s, 2'b01};
                if (r4 >= trial) begin
                    r4 = r4 - trial;
                    s  = {s[32:0], 1'b1};
                end else begin
                    s  = {s[32:0], 1'b0};
                end
                r = r4[34:0];
            end
            v_next[k]   = v;
            rem_next[k] = r;
            rt_next[k]  = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < LSQRT_LAT; k++) begin
                v_reg[k]   <= v_next[k];
                rem_reg[k] <= rem_next[k];
                rt_reg[k]  <= rt_next[k];
            end
        end
    end

    assign root = rt_reg[LSQRT_LAT-1][32:0];

endmodule
